// ----- rtl/nmea_sentence_checker_top_defines.svh -----
// assertion macros for the nmea sentence checker
// used by the top level only, no other dependencies
`ifndef NMEA_SENTENCE_CHECKER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsc assertion failed");
`define NSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsc assertion failed");
`else
`define NSC_ASSERT_IMP(label, ante, cons)
`define NSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/nsc_pkg.sv -----
// types, codes and lookup tables for the nmea sentence checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

    localparam int POS_W      = 10;
    localparam int TYPE_COUNT = 20;
    localparam int NAME_LEN   = 7;
    localparam int TALKER_COUNT = 6;

    localparam logic [POS_W-1:0] POS_MAX          = 10'd1023;
    localparam logic [POS_W-1:0] MAX_LENGTH_RESET = 10'd82;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;

    localparam logic [1:0] FRAME_OK        = 2'd0;
    localparam logic [1:0] FRAME_NO_DOLLAR = 2'd1;
    localparam logic [1:0] FRAME_TOO_LONG  = 2'd2;

    localparam logic [1:0] CSUM_MATCH      = 2'd0;
    localparam logic [1:0] CSUM_MISMATCH   = 2'd1;
    localparam logic [1:0] CSUM_BAD_FORMAT = 2'd2;

    localparam logic [2:0] TALKER_NONE = 3'd0;
    localparam logic [4:0] TYPE_UNKNOWN = 5'd0;

    // names are right-justified, first character in the highest used byte
    localparam logic [NAME_LEN*8-1:0] TYPE_NAMES [TYPE_COUNT] = '{
        "GGA", "GLL", "GSA", "GSV", "RMC", "VTG", "ZDA", "GST", "GNS", "NAVPOS",
        "NAVVEL", "NAVTIME", "NAVACC", "ANTSTAT", "TIMTP", "TIMEM", "LSF", "LPS",
        "SIGNAL", "IPADD"
    };
    localparam int TYPE_LENS [TYPE_COUNT] = '{
        3, 3, 3, 3, 3, 3, 3, 3, 3, 6, 6, 7, 6, 7, 5, 5, 3, 3, 6, 5
    };
    localparam logic [15:0] TALKER_NAMES [TALKER_COUNT] = '{
        "GP", "BD", "GB", "GL", "GA", "GN"
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } nsc_byte_t;

    typedef struct packed {
        logic [1:0]       frame_status;
        logic [1:0]       checksum_status;
        logic [2:0]       talker_id;
        logic [4:0]       sentence_type;
        logic [POS_W-1:0] field_count;
        logic [7:0]       computed_checksum;
        logic [7:0]       received_checksum;
    } nsc_result_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nibble;
    } nsc_hex_t;

    function automatic nsc_hex_t hex_decode(input logic [7:0] c);
        nsc_hex_t h;
        h.valid  = 1'b1;
        h.nibble = 4'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            h.nibble = 4'(c - CHAR_0);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            h.nibble = 4'(c - CHAR_UA + 8'd10);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            h.nibble = 4'(c - CHAR_LA + 8'd10);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [2:0] talker_lookup(input logic [7:0] c1, input logic [7:0] c2);
        logic [2:0] t;
        t = TALKER_NONE;
        // scan backwards so the first entry in the list wins
        for (int i = TALKER_COUNT - 1; i >= 0; i--) begin
            if (c1 == TALKER_NAMES[i][15:8] && c2 == TALKER_NAMES[i][7:0]) begin
                t = 3'(i + 1);
            end
        end
        return t;
    endfunction

    function automatic logic [4:0] type_lookup(input logic [NAME_LEN-1:0][7:0] win,
                                               input logic [3:0] n);
        logic [4:0] t;
        logic       hit;
        int         len;
        int         idx;
        t = TYPE_UNKNOWN;
        for (int i = TYPE_COUNT - 1; i >= 0; i--) begin
            len = TYPE_LENS[i];
            hit = (n == 4'(len));
            for (int k = 0; k < NAME_LEN; k++) begin
                idx = (k < len) ? 8 * (len - 1 - k) : 0;
                if (k < len && win[k] != TYPE_NAMES[i][idx +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                t = 5'(i + 1);
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nsc_in_if.sv -----
// input channel of the nmea sentence checker: one sentence byte per transaction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface nsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/nsc_out_if.sv -----
// result channel of the nmea sentence checker: one report per sentence
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface nsc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] frame_status;
    logic [1:0] checksum_status;
    logic [2:0] talker_id;
    logic [4:0] sentence_type;
    logic [9:0] field_count;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;

    modport source (output valid, output frame_status, output checksum_status,
                    output talker_id, output sentence_type, output field_count,
                    output computed_checksum, output received_checksum, input ready);
    modport sink   (input valid, input frame_status, input checksum_status,
                    input talker_id, input sentence_type, input field_count,
                    input computed_checksum, input received_checksum, output ready);
endinterface

`default_nettype wire

// ----- rtl/nsc_cfg_if.sv -----
// configuration write channel of the nmea sentence checker (max_length)
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface nsc_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/nsc_in_reg.sv -----
// input register: holds one sentence byte until the core takes it
// depends on nsc_pkg and nsc_in_if
`timescale 1ns / 1ps
`default_nettype none

module nsc_in_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    nsc_in_if.sink            sentence,
    output nsc_pkg::nsc_byte_t item,
    output logic              item_valid,
    input  wire logic         item_take
);
    import nsc_pkg::*;

    logic      valid_reg;
    nsc_byte_t item_reg;

    assign sentence.ready = !valid_reg || item_take;
    assign item_valid     = valid_reg;
    assign item           = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sentence.valid && sentence.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sentence.valid && sentence.ready)
        begin
            item_reg.data_byte <= sentence.data_byte;
            item_reg.last_byte <= sentence.last_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nsc_core.sv -----
// sentence state and single-pass result logic of the nmea sentence checker
// depends on nsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module nsc_core #(
    parameter int HEAD_CHARS = 9
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire nsc_pkg::nsc_byte_t       item,
    input  wire logic                     item_valid,
    output logic                          item_take,
    input  wire logic                     res_free,
    input  wire logic [nsc_pkg::POS_W-1:0] max_length,
    output logic                          res_valid,
    output nsc_pkg::nsc_result_t          res
);
    import nsc_pkg::*;

    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic             star_seen_reg, star_seen_next;
    logic [POS_W-1:0] star_pos_reg, star_pos_next;
    logic             delim_seen_reg, delim_seen_next;
    logic [POS_W-1:0] delim_pos_reg, delim_pos_next;
    logic [7:0]       head_reg [HEAD_CHARS];
    logic [7:0]       head_next [HEAD_CHARS];
    logic [7:0]       tail0_reg, tail0_next, tail1_reg, tail1_next;
    logic [POS_W-1:0] delim_cnt_reg, delim_cnt_next;
    logic             dollar_reg, dollar_next;

    logic [7:0]       b;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] type_end;
    logic [POS_W-1:0] type_start;
    logic [NAME_LEN-1:0][7:0] win1, win3;
    nsc_hex_t         hex_hi, hex_lo;
    logic [7:0]       rx_value;

    assign item_take = item_valid && (!item.last_byte || res_free);
    assign res_valid = item_take && item.last_byte;
    assign b   = item.data_byte;
    assign pos = byte_pos_reg;

    // state update for the byte in the input register
    always_comb
    begin
        dollar_next = (pos == '0) ? (b == CHAR_DOLLAR) : dollar_reg;
        for (int i = 0; i < HEAD_CHARS; i++)
        begin
            head_next[i] = (pos == POS_W'(i)) ? b : head_reg[i];
        end
        tail0_next = tail1_reg;
        tail1_next = b;
        delim_cnt_next = delim_cnt_reg;
        if ((b == CHAR_COMMA || b == CHAR_STAR) && delim_cnt_reg < POS_MAX)
        begin
            delim_cnt_next = delim_cnt_reg + 1'b1;
        end
        star_seen_next = star_seen_reg;
        star_pos_next  = star_pos_reg;
        xor_next       = xor_reg;
        if (!star_seen_reg)
        begin
            if (b == CHAR_STAR)
            begin
                star_seen_next = 1'b1;
                star_pos_next  = pos;
            end
            else if (pos != '0)
            begin
                xor_next = xor_reg ^ b;
            end
        end
        delim_seen_next = delim_seen_reg;
        delim_pos_next  = delim_pos_reg;
        if (b == CHAR_COMMA && !delim_seen_reg && pos != '0)
        begin
            delim_seen_next = 1'b1;
            delim_pos_next  = pos;
        end
        byte_pos_next = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
    end

    // type name windows for the two possible start offsets
    always_comb
    begin
        for (int k = 0; k < NAME_LEN; k++)
        begin
            win1[k] = (k + 1 < HEAD_CHARS) ? head_next[(k + 1 < HEAD_CHARS) ? k + 1 : 0] : 8'd0;
            win3[k] = (k + 3 < HEAD_CHARS) ? head_next[(k + 3 < HEAD_CHARS) ? k + 3 : 0] : 8'd0;
        end
    end

    assign hex_hi   = hex_decode(tail0_next);
    assign hex_lo   = hex_decode(tail1_next);
    assign rx_value = {hex_hi.nibble, hex_lo.nibble};

    // result of the sentence ending with this byte
    always_comb
    begin
        if (!dollar_next)
        begin
            res.frame_status = FRAME_NO_DOLLAR;
        end
        else if (byte_pos_next > max_length)
        begin
            res.frame_status = FRAME_TOO_LONG;
        end
        else
        begin
            res.frame_status = FRAME_OK;
        end

        res.talker_id = talker_lookup(head_next[1], head_next[2]);

        type_end = delim_seen_next ? delim_pos_next
                 : (star_seen_next ? star_pos_next : byte_pos_next);
        type_start = (res.talker_id != TALKER_NONE) ? POS_W'(3) : POS_W'(1);
        res.sentence_type = TYPE_UNKNOWN;
        if (res.frame_status == FRAME_OK && type_end >= type_start
            && type_end <= POS_W'(HEAD_CHARS))
        begin
            res.sentence_type = type_lookup((res.talker_id != TALKER_NONE) ? win3 : win1,
                                            4'(type_end - type_start));
        end

        res.received_checksum = 8'd0;
        if (!star_seen_next || byte_pos_next < POS_W'(3)
            || star_pos_next != byte_pos_next - POS_W'(3)
            || !hex_hi.valid || !hex_lo.valid)
        begin
            res.checksum_status = CSUM_BAD_FORMAT;
        end
        else
        begin
            res.received_checksum = rx_value;
            res.checksum_status   = (rx_value == xor_next) ? CSUM_MATCH : CSUM_MISMATCH;
        end

        res.field_count = '0;
        if (res.frame_status == FRAME_OK)
        begin
            res.field_count = (delim_cnt_next < POS_MAX) ? delim_cnt_next + 1'b1 : POS_MAX;
        end
        res.computed_checksum = xor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= '0;
            xor_reg        <= '0;
            star_seen_reg  <= 1'b0;
            star_pos_reg   <= '0;
            delim_seen_reg <= 1'b0;
            delim_pos_reg  <= '0;
            for (int i = 0; i < HEAD_CHARS; i++)
            begin
                head_reg[i] <= '0;
            end
            tail0_reg      <= '0;
            tail1_reg      <= '0;
            delim_cnt_reg  <= '0;
            dollar_reg     <= 1'b0;
        end
        else if (item_take)
        begin
            if (item.last_byte)
            begin
                // sentence done, start the next one from scratch
                byte_pos_reg   <= '0;
                xor_reg        <= '0;
                star_seen_reg  <= 1'b0;
                star_pos_reg   <= '0;
                delim_seen_reg <= 1'b0;
                delim_pos_reg  <= '0;
                for (int i = 0; i < HEAD_CHARS; i++)
                begin
                    head_reg[i] <= '0;
                end
                tail0_reg      <= '0;
                tail1_reg      <= '0;
                delim_cnt_reg  <= '0;
                dollar_reg     <= 1'b0;
            end
            else
            begin
                byte_pos_reg   <= byte_pos_next;
                xor_reg        <= xor_next;
                star_seen_reg  <= star_seen_next;
                star_pos_reg   <= star_pos_next;
                delim_seen_reg <= delim_seen_next;
                delim_pos_reg  <= delim_pos_next;
                for (int i = 0; i < HEAD_CHARS; i++)
                begin
                    head_reg[i] <= head_next[i];
                end
                tail0_reg      <= tail0_next;
                tail1_reg      <= tail1_next;
                delim_cnt_reg  <= delim_cnt_next;
                dollar_reg     <= dollar_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nsc_out_reg.sv -----
// result register: holds one sentence report until the receiver takes it
// depends on nsc_pkg and nsc_out_if
`timescale 1ns / 1ps
`default_nettype none

module nsc_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    input  wire nsc_pkg::nsc_result_t res,
    output logic                      res_free,
    nsc_out_if.source                 report
);
    import nsc_pkg::*;

    logic        valid_reg;
    nsc_result_t res_reg;

    assign res_free = !valid_reg || report.ready;

    assign report.valid             = valid_reg;
    assign report.frame_status      = res_reg.frame_status;
    assign report.checksum_status   = res_reg.checksum_status;
    assign report.talker_id         = res_reg.talker_id;
    assign report.sentence_type     = res_reg.sentence_type;
    assign report.field_count       = res_reg.field_count;
    assign report.computed_checksum = res_reg.computed_checksum;
    assign report.received_checksum = res_reg.received_checksum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nmea_sentence_checker_top.sv -----
// nmea-0183 sentence checker
// sentence: one byte per transaction, last_byte set on the final byte of a sentence.
// report: one transaction per sentence with frame, checksum, talker, type and field count.
// cfg: writes max_length (reset 82); write only while no sentence is in flight.
// a byte accepted into the input register is taken by the core, which updates the sentence
// state and, on the last byte, loads the report register; report.valid comes from that
// register and rises once the last byte has passed through the input and report registers.
// throughput is one byte per cycle unless a final byte waits for the report register.
// while report is stalled, non-final bytes keep flowing; a final byte waits in the input
// register until the held report is taken, and sentence.ready stays low while it waits.
// reset clears all sentence state, empties both registers and restores max_length.
// depends on nsc_pkg, the channel interfaces, the defines header, nsc_in_reg, nsc_core and nsc_out_reg
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_sentence_checker_top_defines.svh"

module nmea_sentence_checker_top #(
    parameter int HEAD_CHARS = 9
) (
    input  wire logic clk,
    input  wire logic rst_n,
    nsc_in_if.sink    sentence,
    nsc_out_if.source report,
    nsc_cfg_if.sink   cfg
);
    import nsc_pkg::*;

    nsc_byte_t        item;
    logic             item_valid;
    logic             item_take;
    logic             res_free;
    logic             res_valid;
    nsc_result_t      res;
    logic [POS_W-1:0] max_length_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_length_reg <= cfg.max_length;
        end
    end

    nsc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .sentence   (sentence),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    nsc_core #(
        .HEAD_CHARS (HEAD_CHARS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .res_free   (res_free),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    nsc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .report    (report)
    );

    // a new report never overwrites one that is still waiting
    `NSC_ASSERT_IMP(a_no_overwrite, res_valid, res_free)
    `NSC_ASSERT_IMP(a_bad_frame_clears, report.valid && report.frame_status != FRAME_OK,
                    report.field_count == '0 && report.sentence_type == TYPE_UNKNOWN)
    `NSC_ASSERT_IMP(a_legal_frame_counts, report.valid && report.frame_status == FRAME_OK,
                    report.field_count != '0)
    `NSC_ASSERT_IMP(a_bad_format_no_rx,
                    report.valid && report.checksum_status == CSUM_BAD_FORMAT,
                    report.received_checksum == 8'd0)

endmodule

`default_nettype wire
